@@ hdl/lbvh_pkg.sv @@
package lbvh_pkg;

    // Fixed field widths
    localparam int KEY_W   = 32;
    localparam int LIDX_W  = 6;
    localparam int SORT_W  = KEY_W + LIDX_W;
    localparam int CHILD_W = 7;
    localparam int NODE_W  = 6;
    localparam int DCODE_W = 7;

    // Split delta: leading zeros of the 64-bit key XOR plus one (1..65).
    // The end sentinels are stored as zero.
    localparam logic [DCODE_W-1:0] DCODE_END = '0;

    function automatic logic [DCODE_W-1:0] delta_code(input logic [SORT_W-1:0] a,
                                                      input logic [SORT_W-1:0] b);
        logic [KEY_W-1:0]   xm;
        logic [LIDX_W-1:0]  xi;
        logic [DCODE_W-1:0] lz;
        xm = a[SORT_W-1:LIDX_W] ^ b[SORT_W-1:LIDX_W];
        xi = a[LIDX_W-1:0] ^ b[LIDX_W-1:0];
        lz = DCODE_W'(64);
        // index bits sit at the bottom of the low key word
        for (int k = 0; k < LIDX_W; k++) begin
            if (xi[k]) lz = DCODE_W'(63 - k);
        end
        // code bits override: highest differing bit wins
        for (int k = 0; k < KEY_W; k++) begin
            if (xm[k]) lz = DCODE_W'(31 - k);
        end
        return lz + DCODE_W'(1);
    endfunction

endpackage

@@ hdl/lbvh_ram.sv @@
module lbvh_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

@@ hdl/lbvh_box_merge.sv @@
module lbvh_box_merge #(
    parameter int COORD_BITS = 16
) (
    input  logic [6*COORD_BITS-1:0] i_box_a,
    input  logic [6*COORD_BITS-1:0] i_box_b,
    output logic [6*COORD_BITS-1:0] o_box
);

    // Take the smaller minimum and the larger maximum per axis
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            if ($signed(i_box_b[k*COORD_BITS +: COORD_BITS])
                    < $signed(i_box_a[k*COORD_BITS +: COORD_BITS])) begin
                o_box[k*COORD_BITS +: COORD_BITS] = i_box_b[k*COORD_BITS +: COORD_BITS];
            end else begin
                o_box[k*COORD_BITS +: COORD_BITS] = i_box_a[k*COORD_BITS +: COORD_BITS];
            end
            if ($signed(i_box_b[(k+3)*COORD_BITS +: COORD_BITS])
                    > $signed(i_box_a[(k+3)*COORD_BITS +: COORD_BITS])) begin
                o_box[(k+3)*COORD_BITS +: COORD_BITS] =
                    i_box_b[(k+3)*COORD_BITS +: COORD_BITS];
            end else begin
                o_box[(k+3)*COORD_BITS +: COORD_BITS] =
                    i_box_a[(k+3)*COORD_BITS +: COORD_BITS];
            end
        end
    end

endmodule

@@ hdl/lbvh_bottom_up_builder_core.sv @@
// Bottom-up linear BVH builder. Leaves are handed in one request at a time
// (start while busy is low). Each is insertion-sorted into the leaf memory on
// arrival, which keeps busy high while larger keys are shifted up. A leaf
// that arrives with the store full is dropped at once. The request with
// final_leaf set starts the build, which first computes the deltas. Then a
// climb runs from every leaf, each climb step reading the deltas and then
// doing a node memory read-modify-write. Finally one result per cycle is
// sent for nodes 0 to n-2, each shown with o_strobe for a single cycle.
// Results cannot be held off by the receiver. busy drops in the cycle in
// which the last node (run_end) is on the outputs.
module lbvh_bottom_up_builder_core #(
    parameter int MAX_LEAVES = 32,
    parameter int COORD_BITS = 16
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  start,
    output logic                                  busy,
    input  logic [lbvh_pkg::KEY_W-1:0]            i_morton_key,
    input  logic [lbvh_pkg::LIDX_W-1:0]           i_leaf_index,
    input  logic signed [COORD_BITS-1:0]          i_box_min_x,
    input  logic signed [COORD_BITS-1:0]          i_box_min_y,
    input  logic signed [COORD_BITS-1:0]          i_box_min_z,
    input  logic signed [COORD_BITS-1:0]          i_box_max_x,
    input  logic signed [COORD_BITS-1:0]          i_box_max_y,
    input  logic signed [COORD_BITS-1:0]          i_box_max_z,
    input  logic                                  i_final_leaf,
    output logic                                  o_strobe,
    output logic [lbvh_pkg::NODE_W-1:0]           o_node_number,
    output logic [lbvh_pkg::CHILD_W-1:0]          o_left_child,
    output logic [lbvh_pkg::CHILD_W-1:0]          o_right_child,
    output logic signed [COORD_BITS-1:0]          o_node_min_x,
    output logic signed [COORD_BITS-1:0]          o_node_min_y,
    output logic signed [COORD_BITS-1:0]          o_node_min_z,
    output logic signed [COORD_BITS-1:0]          o_node_max_x,
    output logic signed [COORD_BITS-1:0]          o_node_max_y,
    output logic signed [COORD_BITS-1:0]          o_node_max_z,
    output logic                                  o_root_flag,
    output logic                                  o_run_end
);
    import lbvh_pkg::*;

    localparam int IW     = $clog2(MAX_LEAVES);
    localparam int CW     = $clog2(MAX_LEAVES + 1);
    localparam int BOX_W  = 6 * COORD_BITS;
    localparam int LEAF_W = SORT_W + BOX_W;
    localparam int NODE_RW = 2 * IW + 2 * CHILD_W + BOX_W;

    typedef enum logic [11:0] {
        S_IDLE     = 12'b0000_0000_0001,
        S_INS      = 12'b0000_0000_0010,
        S_INS_LAST = 12'b0000_0000_0100,
        S_BLD      = 12'b0000_0000_1000,
        S_DLT      = 12'b0000_0001_0000,
        S_DEND     = 12'b0000_0010_0000,
        S_LEAF     = 12'b0000_0100_0000,
        S_DLO      = 12'b0000_1000_0000,
        S_DHI      = 12'b0001_0000_0000,
        S_NODE     = 12'b0010_0000_0000,
        S_NEXT     = 12'b0100_0000_0000,
        S_EMIT     = 12'b1000_0000_0000
    } t_state;

    t_state r_state, n_state;

    logic [CW-1:0]       r_count;
    logic [SORT_W-1:0]   r_new_key;
    logic [BOX_W-1:0]    r_new_box;
    logic                r_final;
    logic [IW-1:0]       r_j;
    logic [IW-1:0]       r_k;
    logic [SORT_W-1:0]   r_prev;
    logic [IW-1:0]       r_i;
    logic [IW-1:0]       r_lo;
    logic [IW-1:0]       r_hi;
    logic [IW-1:0]       r_p;
    logic                r_left;
    logic [CHILD_W-1:0]  r_code;
    logic [BOX_W-1:0]    r_box;
    logic [DCODE_W-1:0]  r_dlo;
    logic [MAX_LEAVES-1:0] r_flags;

    // Memory ports
    logic               leaf_we;
    logic [IW-1:0]      leaf_waddr, leaf_raddr;
    logic [LEAF_W-1:0]  leaf_wdata, leaf_q;
    logic               dlt_we;
    logic [CW-1:0]      dlt_waddr, dlt_raddr;
    logic [DCODE_W-1:0] dlt_wdata, dlt_q;
    logic               node_we;
    logic [IW-1:0]      node_waddr, node_raddr;
    logic [NODE_RW-1:0] node_wdata, node_q;

    // Fields of memory words
    logic [SORT_W-1:0]  q_key;
    logic [BOX_W-1:0]   q_box;
    logic [IW-1:0]      nq_lo, nq_hi;
    logic [CHILD_W-1:0] nq_left, nq_right;
    logic [BOX_W-1:0]   nq_box, merged_box;

    // Climb decision and merge results
    logic               go_left, climb_stop;
    logic [IW-1:0]      parent;
    logic [IW-1:0]      new_lo, new_hi;
    logic [CHILD_W-1:0] new_left, new_right;
    logic               is_root;

    assign q_key    = leaf_q[LEAF_W-1 -: SORT_W];
    assign q_box    = leaf_q[BOX_W-1:0];
    assign nq_box   = node_q[BOX_W-1:0];
    assign nq_right = node_q[BOX_W +: CHILD_W];
    assign nq_left  = node_q[BOX_W + CHILD_W +: CHILD_W];
    assign nq_hi    = node_q[BOX_W + 2*CHILD_W +: IW];
    assign nq_lo    = node_q[BOX_W + 2*CHILD_W + IW +: IW];

    lbvh_ram #(.WIDTH(LEAF_W), .DEPTH(MAX_LEAVES)) u_leaf_ram (
        .i_clk  (i_clk),
        .i_we   (leaf_we),
        .i_waddr(leaf_waddr),
        .i_wdata(leaf_wdata),
        .i_raddr(leaf_raddr),
        .o_rdata(leaf_q)
    );

    lbvh_ram #(.WIDTH(DCODE_W), .DEPTH(MAX_LEAVES + 1)) u_delta_ram (
        .i_clk  (i_clk),
        .i_we   (dlt_we),
        .i_waddr(dlt_waddr),
        .i_wdata(dlt_wdata),
        .i_raddr(dlt_raddr),
        .o_rdata(dlt_q)
    );

    lbvh_ram #(.WIDTH(NODE_RW), .DEPTH(MAX_LEAVES)) u_node_ram (
        .i_clk  (i_clk),
        .i_we   (node_we),
        .i_waddr(node_waddr),
        .i_wdata(node_wdata),
        .i_raddr(node_raddr),
        .o_rdata(node_q)
    );

    lbvh_box_merge #(.COORD_BITS(COORD_BITS)) u_merge (
        .i_box_a(nq_box),
        .i_box_b(r_box),
        .o_box  (merged_box)
    );

    // Pick parent: left child of node hi or right child of node lo-1
    always_comb begin
        go_left    = r_dlo < dlt_q;
        parent     = go_left ? r_hi : (r_lo - IW'(1));
        climb_stop = go_left ? ((CW'(r_hi) + CW'(1)) >= r_count) : (r_lo == '0);
        new_lo     = r_left ? r_lo : nq_lo;
        new_hi     = r_left ? nq_hi : r_hi;
        new_left   = r_left ? r_code : nq_left;
        new_right  = r_left ? nq_right : r_code;
        is_root    = (new_lo == '0) && ((CW'(new_hi) + CW'(1)) == r_count);
    end

    // Sequencer and memory port control
    always_comb begin
        n_state    = r_state;
        leaf_we    = 1'b0;
        leaf_waddr = r_j + IW'(1);
        leaf_wdata = {r_new_key, r_new_box};
        leaf_raddr = '0;
        dlt_we     = 1'b0;
        dlt_waddr  = CW'(r_k);
        dlt_wdata  = delta_code(r_prev, q_key);
        dlt_raddr  = CW'(r_i);
        node_we    = 1'b0;
        node_waddr = r_p;
        node_wdata = {r_lo, r_hi, r_code, r_code, r_box};
        node_raddr = '0;
        case (r_state)
            S_IDLE: begin
                leaf_raddr = IW'(r_count - CW'(1));
                if (start) begin
                    if (r_count == CW'(MAX_LEAVES)) begin
                        n_state = i_final_leaf ? S_BLD : S_IDLE;
                    end else if (r_count == '0) begin
                        n_state = S_INS_LAST;
                    end else begin
                        n_state = S_INS;
                    end
                end
            end
            S_INS: begin
                leaf_we    = 1'b1;
                leaf_raddr = r_j - IW'(1);
                if (q_key > r_new_key) begin
                    // shift the larger key up one slot
                    leaf_wdata = leaf_q;
                    n_state    = (r_j == '0) ? S_INS_LAST : S_INS;
                end else begin
                    n_state = r_final ? S_BLD : S_IDLE;
                end
            end
            S_INS_LAST: begin
                leaf_we    = 1'b1;
                leaf_waddr = '0;
                n_state    = r_final ? S_BLD : S_IDLE;
            end
            S_BLD: begin
                leaf_raddr = '0;
                dlt_we     = (r_count >= CW'(2));
                dlt_waddr  = '0;
                dlt_wdata  = DCODE_END;
                n_state    = (r_count >= CW'(2)) ? S_DLT : S_IDLE;
            end
            S_DLT: begin
                dlt_we     = (r_k != '0);
                leaf_raddr = r_k + IW'(1);
                n_state    = ((CW'(r_k) + CW'(1)) == r_count) ? S_DEND : S_DLT;
            end
            S_DEND: begin
                dlt_we     = 1'b1;
                dlt_waddr  = r_count;
                dlt_wdata  = DCODE_END;
                leaf_raddr = '0;
                n_state    = S_LEAF;
            end
            S_LEAF: begin
                dlt_raddr = CW'(r_i);
                n_state   = S_DLO;
            end
            S_DLO: begin
                dlt_raddr = CW'(r_hi) + CW'(1);
                n_state   = S_DHI;
            end
            S_DHI: begin
                node_raddr = parent;
                n_state    = climb_stop ? S_NEXT : S_NODE;
            end
            S_NODE: begin
                node_we = 1'b1;
                if (r_flags[r_p]) begin
                    node_wdata = {new_lo, new_hi, new_left, new_right, merged_box};
                    dlt_raddr  = CW'(new_lo);
                    n_state    = is_root ? S_NEXT : S_DLO;
                end else begin
                    n_state = S_NEXT;
                end
            end
            S_NEXT: begin
                leaf_raddr = r_i + IW'(1);
                node_raddr = '0;
                n_state    = ((CW'(r_i) + CW'(1)) == r_count) ? S_EMIT : S_LEAF;
            end
            S_EMIT: begin
                node_raddr = r_k + IW'(1);
                n_state    = ((CW'(r_k) + CW'(2)) == r_count) ? S_IDLE : S_EMIT;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_count  <= '0;
            r_flags  <= '0;
            o_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            o_strobe <= 1'b0;
            case (r_state)
                S_INS: begin
                    if (!(q_key > r_new_key)) begin
                        r_count <= r_count + CW'(1);
                    end
                end
                S_INS_LAST: begin
                    r_count <= r_count + CW'(1);
                end
                S_BLD: begin
                    r_flags <= '0;
                    if (r_count < CW'(2)) begin
                        r_count <= '0;
                    end
                end
                S_NODE: begin
                    r_flags[r_p] <= 1'b1;
                end
                S_EMIT: begin
                    o_strobe <= 1'b1;
                    if ((CW'(r_k) + CW'(2)) == r_count) begin
                        r_count <= '0;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                r_new_key <= {i_morton_key, i_leaf_index};
                r_new_box <= {i_box_max_z, i_box_max_y, i_box_max_x,
                              i_box_min_z, i_box_min_y, i_box_min_x};
                r_final   <= i_final_leaf;
                r_j       <= IW'(r_count - CW'(1));
            end
            S_INS: begin
                r_j <= r_j - IW'(1);
            end
            S_BLD: begin
                r_k <= '0;
            end
            S_DLT: begin
                r_prev <= q_key;
                r_k    <= r_k + IW'(1);
            end
            S_DEND: begin
                r_i <= '0;
            end
            S_LEAF: begin
                r_lo   <= r_i;
                r_hi   <= r_i;
                r_code <= CHILD_W'(q_key[LIDX_W-1:0]);
                r_box  <= q_box;
            end
            S_DLO: begin
                r_dlo <= dlt_q;
            end
            S_DHI: begin
                r_p    <= parent;
                r_left <= go_left;
            end
            S_NODE: begin
                r_lo   <= new_lo;
                r_hi   <= new_hi;
                r_code <= CHILD_W'(MAX_LEAVES + int'(r_p));
                r_box  <= merged_box;
            end
            S_NEXT: begin
                r_i <= r_i + IW'(1);
                r_k <= '0;
            end
            S_EMIT: begin
                o_node_number <= NODE_W'(r_k);
                o_left_child  <= nq_left;
                o_right_child <= nq_right;
                o_node_min_x  <= nq_box[0*COORD_BITS +: COORD_BITS];
                o_node_min_y  <= nq_box[1*COORD_BITS +: COORD_BITS];
                o_node_min_z  <= nq_box[2*COORD_BITS +: COORD_BITS];
                o_node_max_x  <= nq_box[3*COORD_BITS +: COORD_BITS];
                o_node_max_y  <= nq_box[4*COORD_BITS +: COORD_BITS];
                o_node_max_z  <= nq_box[5*COORD_BITS +: COORD_BITS];
                o_root_flag   <= (nq_lo == '0) && ((CW'(nq_hi) + CW'(1)) == r_count);
                o_run_end     <= (CW'(r_k) + CW'(2)) == r_count;
                r_k           <= r_k + IW'(1);
            end
            default: begin
            end
        endcase
    end

    assign busy = (r_state != S_IDLE);

endmodule

@@ tb/lbvh_bottom_up_builder_core_tb.sv @@
module lbvh_bottom_up_builder_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAXL = 32;
    localparam int LIMIT_CYC = 600000;

    typedef struct packed {
        logic [31:0]      morton;
        logic [5:0]       idx;
        logic [5:0][15:0] box;
        logic             fin;
    } leaf_t;

    typedef struct packed {
        logic [5:0]       num;
        logic [6:0]       lc;
        logic [6:0]       rc;
        logic [5:0][15:0] box;
        logic             root;
        logic             last;
    } node_t;

    // Holds the pending leaf set and the nodes still owed by the block
    class tree_scoreboard;
        logic [63:0] keys[MAXL];
        int          boxes[MAXL][6];
        int          count;
        node_t       owed[$];
        int          errs;
        int          nodes_seen;
        int          sets;

        function new();
            count = 0;
            errs = 0;
            nodes_seen = 0;
            sets = 0;
        endfunction

        function int lead_zeros(logic [63:0] x);
            for (int b = 63; b >= 0; b--) begin
                if (x[b]) return 63 - b;
            end
            return 64;
        endfunction

        // Store one accepted leaf request; a final leaf builds the tree
        function void note_leaf(leaf_t lf);
            if (count < MAXL) begin
                keys[count] = {lf.morton, 26'd0, lf.idx};
                for (int a = 0; a < 6; a++) boxes[count][a] = $signed(lf.box[a]);
                count++;
            end
            if (lf.fin) begin
                build_tree();
                count = 0;
                sets++;
            end
        endfunction

        function void build_tree();
            int n, j, lo, hi, p, id;
            bit leaf;
            logic [63:0] k;
            logic [6:0] code;
            int b[6];
            int src[6];
            int delta[MAXL+1];
            int nlo[MAXL], nhi[MAXL];
            logic [6:0] nl[MAXL], nr[MAXL];
            int nbox[MAXL][6];
            bit arrived[MAXL];
            node_t nd;
            n = count;
            if (n < 2) return;
            for (int i = 0; i < MAXL; i++) begin
                nlo[i] = 0; nhi[i] = 0; nl[i] = 0; nr[i] = 0; arrived[i] = 0;
                for (int a = 0; a < 6; a++) nbox[i][a] = 0;
            end
            // stable insertion sort of keys with their boxes
            for (int i = 1; i < n; i++) begin
                k = keys[i];
                for (int a = 0; a < 6; a++) b[a] = boxes[i][a];
                j = i - 1;
                while (j >= 0 && keys[j] > k) begin
                    keys[j+1] = keys[j];
                    for (int a = 0; a < 6; a++) boxes[j+1][a] = boxes[j][a];
                    j--;
                end
                keys[j+1] = k;
                for (int a = 0; a < 6; a++) boxes[j+1][a] = b[a];
            end
            delta[0] = -1;
            delta[n] = -1;
            for (int i = 1; i < n; i++) delta[i] = lead_zeros(keys[i-1] ^ keys[i]);
            // climb from every leaf; second arrival carries on upward
            for (int i = 0; i < n; i++) begin
                leaf = 1;
                id = i;
                for (int s = 0; s <= 2 * n; s++) begin
                    lo = leaf ? id : nlo[id];
                    hi = leaf ? id : nhi[id];
                    code = leaf ? keys[id][6:0] : 7'(MAXL + id);
                    if (lo < 0 || hi < 0 || lo >= n || hi >= n) break;
                    for (int a = 0; a < 6; a++) src[a] = leaf ? boxes[id][a] : nbox[id][a];
                    if (delta[lo] < delta[hi+1]) begin
                        p = hi;
                        if (p > n - 2) break;
                        nlo[p] = lo;
                        nl[p] = code;
                    end else begin
                        if (lo == 0) break;
                        p = lo - 1;
                        nhi[p] = hi;
                        nr[p] = code;
                    end
                    if (!arrived[p]) begin
                        for (int a = 0; a < 6; a++) nbox[p][a] = src[a];
                        arrived[p] = 1;
                        break;
                    end
                    for (int a = 0; a < 3; a++) begin
                        if (src[a] < nbox[p][a]) nbox[p][a] = src[a];
                        if (src[a+3] > nbox[p][a+3]) nbox[p][a+3] = src[a+3];
                    end
                    if (nlo[p] == 0 && nhi[p] == n - 1) break;
                    leaf = 0;
                    id = p;
                end
            end
            for (int i = 0; i < n - 1; i++) begin
                nd.num = 6'(i);
                nd.lc = nl[i];
                nd.rc = nr[i];
                for (int a = 0; a < 6; a++) nd.box[a] = 16'(nbox[i][a]);
                nd.root = (nlo[i] == 0 && nhi[i] == n - 1);
                nd.last = (i == n - 2);
                owed.insert(owed.size(), nd);
            end
        endfunction

        // Compare one strobed node against the oldest owed node
        function void check_node(node_t act);
            node_t ex;
            string bname[6];
            bname = '{"node_min_x", "node_min_y", "node_min_z",
                      "node_max_x", "node_max_y", "node_max_z"};
            nodes_seen++;
            if (owed.size() == 0) begin
                $error("unexpected node %0d", act.num);
                errs++;
                return;
            end
            ex = owed.pop_front();
            if (act.num !== ex.num) begin
                $error("node_number expected %0d got %0d", ex.num, act.num); errs++;
            end
            if (act.lc !== ex.lc) begin
                $error("left_child expected %0d got %0d", ex.lc, act.lc); errs++;
            end
            if (act.rc !== ex.rc) begin
                $error("right_child expected %0d got %0d", ex.rc, act.rc); errs++;
            end
            for (int a = 0; a < 6; a++) begin
                if (act.box[a] !== ex.box[a]) begin
                    $error("%s expected %0d got %0d", bname[a],
                           $signed(ex.box[a]), $signed(act.box[a]));
                    errs++;
                end
            end
            if (act.root !== ex.root) begin
                $error("root_flag expected %0d got %0d", ex.root, act.root); errs++;
            end
            if (act.last !== ex.last) begin
                $error("run_end expected %0d got %0d", ex.last, act.last); errs++;
            end
        endfunction
    endclass

    logic i_clk, i_rst_n, start, busy;
    logic [31:0] i_morton_key;
    logic [5:0]  i_leaf_index;
    logic signed [15:0] i_box_min_x, i_box_min_y, i_box_min_z;
    logic signed [15:0] i_box_max_x, i_box_max_y, i_box_max_z;
    logic i_final_leaf;
    logic o_strobe;
    logic [5:0] o_node_number;
    logic [6:0] o_left_child, o_right_child;
    logic signed [15:0] o_node_min_x, o_node_min_y, o_node_min_z;
    logic signed [15:0] o_node_max_x, o_node_max_y, o_node_max_z;
    logic o_root_flag, o_run_end;

    tree_scoreboard sb;
    int cyc;
    int items;
    bit calm;

    lbvh_bottom_up_builder_core uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_morton_key(i_morton_key), .i_leaf_index(i_leaf_index),
        .i_box_min_x(i_box_min_x), .i_box_min_y(i_box_min_y), .i_box_min_z(i_box_min_z),
        .i_box_max_x(i_box_max_x), .i_box_max_y(i_box_max_y), .i_box_max_z(i_box_max_z),
        .i_final_leaf(i_final_leaf), .o_strobe(o_strobe),
        .o_node_number(o_node_number), .o_left_child(o_left_child),
        .o_right_child(o_right_child),
        .o_node_min_x(o_node_min_x), .o_node_min_y(o_node_min_y),
        .o_node_min_z(o_node_min_z),
        .o_node_max_x(o_node_max_x), .o_node_max_y(o_node_max_y),
        .o_node_max_z(o_node_max_z),
        .o_root_flag(o_root_flag), .o_run_end(o_run_end)
    );

    initial begin
        i_clk = 0;
        forever #1 i_clk = ~i_clk;
    end

    // Abort on a hung run
    always @(posedge i_clk) begin
        cyc <= cyc + 1;
        if (cyc > LIMIT_CYC) begin
            $display("lbvh_bottom_up_builder_core_tb NOT OK");
            $finish;
        end
    end

    // Check every strobed node
    always @(posedge i_clk) begin
        if (i_rst_n && o_strobe)
            sb.check_node({o_node_number, o_left_child, o_right_child,
                           o_node_max_z, o_node_max_y, o_node_max_x,
                           o_node_min_z, o_node_min_y, o_node_min_x,
                           o_root_flag, o_run_end});
    end

    // Present one leaf request and hold it until accepted
    task automatic send_leaf(leaf_t lf);
        @(negedge i_clk);
        start = 1;
        i_morton_key = lf.morton;
        i_leaf_index = lf.idx;
        {i_box_max_z, i_box_max_y, i_box_max_x,
         i_box_min_z, i_box_min_y, i_box_min_x} = lf.box;
        i_final_leaf = lf.fin;
        do @(posedge i_clk); while (busy);
        sb.note_leaf(lf);
        items++;
        if (!calm && $urandom_range(0, 3) == 0) begin
            @(negedge i_clk);
            start = 0;
            repeat ($urandom_range(0, 5)) @(negedge i_clk);
        end
    endtask

    function automatic leaf_t rand_leaf(logic [31:0] base, int mode);
        leaf_t lf;
        case (mode)
            0: lf.morton = $urandom;
            1: lf.morton = base ^ (32'd1 << $urandom_range(0, 31));
            default: lf.morton = base;
        endcase
        lf.idx = 6'($urandom_range(0, 63));
        for (int a = 0; a < 6; a++) lf.box[a] = 16'($urandom);
        lf.fin = 0;
        return lf;
    endfunction

    // Send a set of n leaves, last one closing the set
    task automatic send_set(int n);
        leaf_t lf;
        logic [31:0] base;
        int mode;
        base = $urandom;
        mode = $urandom_range(0, 2);
        for (int i = 0; i < n; i++) begin
            lf = rand_leaf(base, (mode == 0) ? 0 : $urandom_range(0, 2));
            lf.fin = (i == n - 1);
            send_leaf(lf);
        end
    endtask

    // Drop start, then wait for every owed node
    task automatic drain();
        @(negedge i_clk);
        start = 0;
        while (sb.owed.size() != 0 || busy) @(posedge i_clk);
    endtask

    initial begin
        leaf_t lf;
        sb = new();
        cyc = 0;
        items = 0;
        calm = 0;
        i_rst_n = 0;
        start = 0;
        i_morton_key = 0;
        i_leaf_index = 0;
        {i_box_min_x, i_box_min_y, i_box_min_z} = '0;
        {i_box_max_x, i_box_max_y, i_box_max_z} = '0;
        i_final_leaf = 0;
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1;

        // extremes of key, index and box
        send_leaf('{32'h0, 6'd63, {6{16'h7fff}}, 1'b0});
        send_leaf('{32'hffffffff, 6'd0, {6{16'h8000}}, 1'b1});
        // single leaf gives no node
        send_leaf('{32'h1234, 6'd5, {16'd10, 16'd9, 16'd8, 16'd1, 16'd2, 16'd3}, 1'b1});
        // equal keys keep arrival order; large indexes; inverted boxes
        send_leaf('{32'h55, 6'd40, {16'd1, 16'd1, 16'd1, 16'd9, 16'd9, 16'd9}, 1'b0});
        send_leaf('{32'h55, 6'd40, {16'd7, 16'd2, 16'h8000, 16'd0, 16'd5, 16'd4}, 1'b0});
        send_leaf('{32'h55, 6'd33, {16'hfff0, 16'd3, 16'd3, 16'd3, 16'd3, 16'h7fff}, 1'b0});
        send_leaf('{32'h54, 6'd63, {16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0}, 1'b0});
        send_leaf('{32'h80000000, 6'd32, {16'h1234, 16'h4321, 16'd5, 16'd6,
                                          16'd7, 16'd8}, 1'b1});
        drain();
        for (int i = 0; i < 6; i++) begin
            lf = rand_leaf(32'hA5A5A5A5, 1);
            lf.fin = (i == 5);
            send_leaf(lf);
        end

        // overflow: leaves beyond the store are dropped
        send_set(MAXL + 2);

        // random sets, mostly small, one full
        send_set(MAXL);
        while (items < 90) begin
            send_set($urandom_range(0, 7) == 0 ? $urandom_range(9, 20)
                                                : $urandom_range(1, 8));
            if ($urandom_range(0, 4) == 0) drain();
        end
        calm = 1;
        while (items < 108) send_set($urandom_range(2, 8));

        @(negedge i_clk);
        start = 0;
        i_final_leaf = 0;
        drain();
        repeat (50) @(posedge i_clk);
        $display("Ran %0d leaf requests in %0d sets, %0d nodes checked", items, sb.sets,
                 sb.nodes_seen);
        if (sb.errs == 0 && sb.owed.size() == 0) begin
            $display("lbvh_bottom_up_builder_core_tb OK");
        end else begin
            $display("lbvh_bottom_up_builder_core_tb NOT OK");
        end
        $finish;
    end
endmodule
